[hw/rtl/noctce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noctce_pkg
// Shared types, codes and helpers for the NoC link load estimator.
// ----------------------------------------------------------------------------
package noctce_pkg;

  localparam int MAX_CORES = 16;

  localparam int SIZE_W  = 32;
  localparam int SER_W   = 33;
  localparam int HOP_W   = 6;
  localparam int LAT_W   = 16;
  localparam int ROUTE_W = HOP_W + LAT_W;
  localparam int SUM_W   = SER_W + 1;
  localparam int ISO_W   = HOP_W + SUM_W;
  localparam int LOAD_W  = 64;
  localparam int CFG_W   = 16;
  localparam int OUT_DW  = 208;

  localparam logic [2:0] REG_CORE_COUNT = 3'd0;
  localparam logic [2:0] REG_TOPOLOGY   = 3'd1;
  localparam logic [2:0] REG_MESH_COLS  = 3'd2;
  localparam logic [2:0] REG_HOP_LAT    = 3'd3;
  localparam logic [2:0] REG_SWITCH     = 3'd4;
  localparam logic [2:0] REG_CONTENTION = 3'd5;
  localparam logic [2:0] REG_ROUTE_ORD  = 3'd6;
  localparam logic [2:0] REG_LINK_WIDTH = 3'd7;

  localparam logic [1:0] TOPO_RING = 2'd1;
  localparam logic [1:0] TOPO_MESH = 2'd2;

  localparam logic [1:0] SW_HOP_ONLY = 2'd0;
  localparam logic [1:0] SW_CUT      = 2'd1;
  localparam logic [1:0] SW_SAF      = 2'd2;

  typedef enum logic [9:0] {
    ST_CLR  = 10'b00_0000_0001,
    ST_IDLE = 10'b00_0000_0010,
    ST_CHK  = 10'b00_0000_0100,
    ST_DIV  = 10'b00_0000_1000,
    ST_CAL1 = 10'b00_0001_0000,
    ST_CAL2 = 10'b00_0010_0000,
    ST_WRD  = 10'b00_0100_0000,
    ST_WWR  = 10'b00_1000_0000,
    ST_SCAN = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } noctce_state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic set_err;
    logic div_step;
    logic calc1;
    logic calc2;
    logic walk_rd;
    logic walk_wr;
    logic scan_start;
    logic scan_step;
    logic clr_step;
    logic out_load;
  } noctce_cmd_t;

  typedef struct packed {
    logic err;
    logic pre_bad;
    logic div_done;
    logic iso_bad;
    logic at_dst;
    logic nx_bad;
    logic arrive;
    logic last;
    logic scan_done;
    logic clr_done;
    logic out_busy;
  } noctce_sts_t;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
  } noctce_pos_t;

  // 4-step restoring divide of a node number by the column count
  function automatic noctce_pos_t node_pos(input logic [3:0] a, input logic [4:0] b);
    logic [5:0]  r;
    noctce_pos_t p;
    r = '0;
    p = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[4:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        p.row[i] = 1'b1;
      end
    end
    p.col = r[3:0];
    return p;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/noc_traffic_contention_estimator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noc_traffic_contention_estimator
// Per-batch NoC link load and transfer time estimate over ring or mesh.
// ----------------------------------------------------------------------------
// One message word at a time. A message is taken and checked, then passes
// through the bit-serial ceil(size / link width) divider and the route
// arithmetic, then does a read-modify-write of the link load memory for each
// link on its route. A rejected or skipped message ends at the check. The word
// marked tlast adds a scan of all MAX_CORES*MAX_CORES links, one per cycle,
// which also zeroes the memory. After reset the memory is zeroed before the
// first word is taken. A pending result does not stall input; a new batch end
// waits only for the result register.
// ----------------------------------------------------------------------------
module noc_traffic_contention_estimator import noctce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,   // source core, destination core,
                                             // byte count
  input  wire logic              in_tlast,   // last message of the batch
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // overall estimate, isolated time,
                                             // bottleneck load, bottleneck flag,
                                             // bottleneck source, bottleneck sink
  output logic                   out_tuser   // status
);

  noctce_cmd_t cmd;
  noctce_sts_t sts;

  noctce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  noctce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

[hw/rtl/noctce_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noctce_ctrl
// Sequencer: memory clear, check, divide, route time, link walk, final scan and report.
// ----------------------------------------------------------------------------
module noctce_ctrl import noctce_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  noctce_sts_t      sts,
  output noctce_cmd_t      cmd
);

  noctce_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        // a batch already in error skips straight to the end check
        if (sts.err) begin
          state_nxt = sts.last ? ST_SCAN : ST_IDLE;
          cmd.scan_start = sts.last;
        end else if (sts.pre_bad) begin
          cmd.set_err = 1'b1;
          state_nxt = sts.last ? ST_SCAN : ST_IDLE;
          cmd.scan_start = sts.last;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_CAL1;
      end
      ST_CAL1: begin
        cmd.calc1 = 1'b1;
        state_nxt = ST_CAL2;
      end
      ST_CAL2: begin
        cmd.calc2 = 1'b1;
        if (sts.iso_bad || sts.at_dst) begin
          cmd.set_err    = sts.iso_bad;
          cmd.scan_start = sts.last;
          state_nxt      = sts.last ? ST_SCAN : ST_IDLE;
        end else begin
          state_nxt = ST_WRD;
        end
      end
      ST_WRD: begin
        if (sts.nx_bad) begin
          cmd.set_err    = 1'b1;
          cmd.scan_start = sts.last;
          state_nxt      = sts.last ? ST_SCAN : ST_IDLE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_WWR;
        end
      end
      ST_WWR: begin
        cmd.walk_wr = 1'b1;
        if (sts.arrive) begin
          cmd.scan_start = sts.last;
          state_nxt      = sts.last ? ST_SCAN : ST_IDLE;
        end else begin
          state_nxt = ST_WRD;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/noctce_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noctce_dp
// Config registers, divider, route arithmetic, link load memory, result reg.
// ----------------------------------------------------------------------------
module noctce_dp import noctce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [39:0]       in_tdata,
  input  wire logic              in_tlast,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic                   out_tuser,
  input  noctce_cmd_t            cmd,
  output noctce_sts_t            sts
);

  localparam int NW    = $clog2(MAX_CORES);
  localparam int DEPTH = MAX_CORES * MAX_CORES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  // configuration
  logic [4:0]       core_count_r, mesh_w_r;
  logic [1:0]       topo_r, switch_r;
  logic [LAT_W-1:0] hop_lat_r;
  logic             contention_r, route_ord_r;
  logic [6:0]       link_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r <= 5'd16;
      topo_r       <= TOPO_RING;
      mesh_w_r     <= 5'd4;
      hop_lat_r    <= 16'd1;
      switch_r     <= SW_CUT;
      contention_r <= 1'b0;
      route_ord_r  <= 1'b0;
      link_w_r     <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORE_COUNT: core_count_r <= cfg_wdata[4:0];
        REG_TOPOLOGY:   topo_r       <= cfg_wdata[1:0];
        REG_MESH_COLS:  mesh_w_r     <= cfg_wdata[4:0];
        REG_HOP_LAT:    hop_lat_r    <= cfg_wdata;
        REG_SWITCH:     switch_r     <= cfg_wdata[1:0];
        REG_CONTENTION: contention_r <= cfg_wdata[0];
        REG_ROUTE_ORD:  route_ord_r  <= cfg_wdata[0];
        REG_LINK_WIDTH: link_w_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic [8:0] n9;
  logic [4:0] cols;
  logic [6:0] lw;
  assign n9   = (9'(core_count_r) > 9'(MAX_CORES)) ? 9'(MAX_CORES) : 9'(core_count_r);
  assign cols = (mesh_w_r == 5'd0) ? 5'd1 : mesh_w_r;
  assign lw   = (link_w_r == 7'd0) ? 7'd1 : link_w_r;

  // message word
  logic [3:0]        src_r, dst_r;
  logic [SIZE_W-1:0] size_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src_r  <= in_tdata[3:0];
      dst_r  <= in_tdata[7:4];
      size_r <= in_tdata[39:8];
      last_r <= in_tlast;
    end
  end

  // geometry
  logic [8:0]       fw, bw;
  logic [HOP_W-1:0] ring_hops, mesh_hops;
  noctce_pos_t      sp, dp;
  assign fw = (dst_r >= src_r) ? 9'(dst_r - src_r) : 9'(dst_r) + n9 - 9'(src_r);
  assign bw = (src_r >= dst_r) ? 9'(src_r - dst_r) : 9'(src_r) + n9 - 9'(dst_r);
  assign ring_hops = (fw < bw) ? HOP_W'(fw) : HOP_W'(bw);
  assign sp = node_pos(src_r, cols);
  assign dp = node_pos(dst_r, cols);
  assign mesh_hops = HOP_W'((sp.row > dp.row) ? sp.row - dp.row : dp.row - sp.row)
                   + HOP_W'((sp.col > dp.col) ? sp.col - dp.col : dp.col - sp.col);

  logic             err_r;
  logic [HOP_W-1:0] hops_r;
  logic             cw_r;
  logic [NW-1:0]    cur_r, dnode_r, nx_r;
  logic [3:0]       crow_r, ccol_r, drow_r, dcol_r, nrow_r, ncol_r;

  // divider
  logic [SIZE_W-1:0] dq_r;
  logic [6:0]        rem_r;
  logic [4:0]        dcnt_r;
  logic [7:0]        dsh;
  logic              dge;
  logic [SER_W-1:0]  ser;
  assign dsh = {rem_r, dq_r[SIZE_W-1]};
  assign dge = dsh >= {1'b0, lw};
  assign ser = SER_W'(dq_r) + SER_W'(rem_r != 7'd0);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      hops_r  <= (src_r == dst_r) ? '0 : ((topo_r == TOPO_RING) ? ring_hops : mesh_hops);
      cw_r    <= fw <= bw;
      cur_r   <= NW'(src_r);
      dnode_r <= NW'(dst_r);
      crow_r  <= sp.row;
      ccol_r  <= sp.col;
      drow_r  <= dp.row;
      dcol_r  <= dp.col;
      dq_r    <= size_r;
      rem_r   <= '0;
      dcnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= dge ? 7'(dsh - {1'b0, lw}) : dsh[6:0];
      dq_r   <= {dq_r[SIZE_W-2:0], dge};
      dcnt_r <= dcnt_r + 5'd1;
    end else if (cmd.walk_wr) begin
      cur_r  <= nx_r;
      crow_r <= nrow_r;
      ccol_r <= ncol_r;
    end
  end

  // route and isolated time
  logic [ROUTE_W-1:0] route_r, max_route_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SER_W-1:0]   ser_r, cost_r;
  logic [ISO_W-1:0]   iso, max_iso_r;
  logic               no_iso;
  assign no_iso = (hops_r == '0) || (size_r == '0);

  always_comb begin
    case (switch_r)
      SW_HOP_ONLY: iso = ISO_W'(route_r);
      SW_CUT:      iso = ISO_W'(route_r) + ISO_W'(ser_r);
      SW_SAF:      iso = ISO_W'(hops_r) * ISO_W'(sum_r);
      default:     iso = '0;
    endcase
    if (no_iso) iso = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      route_r <= ROUTE_W'(hops_r) * ROUTE_W'(hop_lat_r);
      sum_r   <= SUM_W'(hop_lat_r) + SUM_W'(ser);
      ser_r   <= ser;
    end
    if (cmd.calc2) begin
      cost_r <= (switch_r != SW_HOP_ONLY && size_r != '0) ? ser_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= 1'b0;
      max_iso_r   <= '0;
      max_route_r <= '0;
    end else if (cmd.out_load) begin
      err_r       <= 1'b0;
      max_iso_r   <= '0;
      max_route_r <= '0;
    end else begin
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.calc2) begin
        if (iso > max_iso_r) max_iso_r <= iso;
        if (route_r > max_route_r) max_route_r <= route_r;
      end
    end
  end

  // next hop
  logic [8:0] cur9, nx_ring;
  logic [9:0] nx_mesh;
  logic       move_x, go_right, go_down;
  logic [NW-1:0] nx;
  logic [3:0]    nrow, ncol;
  assign cur9     = 9'(cur_r);
  assign nx_ring  = cw_r ? ((cur9 + 9'd1 == n9) ? 9'd0 : cur9 + 9'd1)
                         : ((cur9 == 9'd0) ? n9 - 9'd1 : cur9 - 9'd1);
  assign move_x   = route_ord_r ? (crow_r == drow_r) : (ccol_r != dcol_r);
  assign go_right = ccol_r < dcol_r;
  assign go_down  = crow_r < drow_r;
  always_comb begin
    nrow = crow_r;
    ncol = ccol_r;
    if (move_x) begin
      nx_mesh = go_right ? 10'(cur_r) + 10'd1 : 10'(cur_r) - 10'd1;
      ncol    = go_right ? ccol_r + 4'd1 : ccol_r - 4'd1;
    end else begin
      nx_mesh = go_down ? 10'(cur_r) + 10'(cols) : 10'(cur_r) - 10'(cols);
      nrow    = go_down ? crow_r + 4'd1 : crow_r - 4'd1;
    end
  end
  assign nx = (topo_r == TOPO_MESH) ? NW'(nx_mesh) : NW'(nx_ring);

  // link load memory
  logic [LOAD_W-1:0] mem [DEPTH];
  logic [LOAD_W-1:0] rdata_r, mem_wd;
  logic [AW-1:0]     walk_idx, waddr_r, rd_addr, mem_wa;
  logic              mem_we;
  logic [CW-1:0]     cnt_r;
  logic [64:0]       lsum;
  assign walk_idx = AW'(cur_r) * AW'(MAX_CORES) + AW'(nx);
  assign rd_addr  = cmd.scan_step ? cnt_r[AW-1:0] : walk_idx;
  assign lsum     = 65'(rdata_r) + 65'(cost_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = waddr_r;
    mem_wd = '0;
    if (cmd.walk_wr) begin
      mem_we = 1'b1;
      mem_wd = lsum[64] ? '1 : lsum[63:0];
    end else if (cmd.scan_step) begin
      // zero the entry whose data comes back this cycle
      mem_we = cnt_r != '0;
      mem_wa = AW'(cnt_r - CW'(1));
    end else if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      waddr_r <= walk_idx;
      nx_r    <= nx;
      nrow_r  <= nrow;
      ncol_r  <= ncol;
    end
  end

  // scan
  logic [NW-1:0]     s_r, t_r, ps_r, pt_r, bf_r, bt_r;
  logic [LOAD_W-1:0] best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.scan_start) begin
      cnt_r <= '0;
    end else if (cmd.scan_step || cmd.clr_step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      s_r    <= '0;
      t_r    <= '0;
      best_r <= '0;
      bf_r   <= '0;
      bt_r   <= '0;
    end else if (cmd.scan_step) begin
      t_r  <= (t_r == NW'(MAX_CORES - 1)) ? '0 : t_r + NW'(1);
      if (t_r == NW'(MAX_CORES - 1)) s_r <= s_r + NW'(1);
      ps_r <= s_r;
      pt_r <= t_r;
      if (cnt_r != '0 && rdata_r > best_r) begin
        best_r <= rdata_r;
        bf_r   <= ps_r;
        bt_r   <= pt_r;
      end
    end
  end

  // result register
  logic [64:0]       bsum;
  logic [LOAD_W-1:0] bound, est;
  logic              out_valid_r;
  assign bsum  = 65'(best_r) + 65'(max_route_r);
  assign bound = bsum[64] ? '1 : bsum[63:0];
  assign est   = (contention_r && bound > LOAD_W'(max_iso_r)) ? bound : LOAD_W'(max_iso_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tuser <= err_r;
      if (err_r) begin
        out_tdata <= '0;
      end else begin
        out_tdata <= {7'd0, 4'(bt_r), 4'(bf_r), best_r != '0, best_r,
                      LOAD_W'(max_iso_r), est};
      end
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    sts           = '0;
    sts.err       = err_r;
    sts.pre_bad   = (9'(src_r) >= n9) || (9'(dst_r) >= n9) ||
                    (src_r != dst_r && topo_r != TOPO_RING && topo_r != TOPO_MESH);
    sts.div_done  = dcnt_r == 5'd31;
    sts.iso_bad   = switch_r != SW_HOP_ONLY && switch_r != SW_CUT && switch_r != SW_SAF
                    && !no_iso;
    sts.at_dst    = cur_r == dnode_r;
    sts.nx_bad    = (topo_r == TOPO_MESH) && (nx_mesh >= 10'(n9));
    sts.arrive    = nx_r == dnode_r;
    sts.last      = last_r;
    sts.scan_done = cnt_r == CW'(DEPTH);
    sts.clr_done  = cnt_r == CW'(DEPTH - 1);
    sts.out_busy  = out_valid_r && !out_tready;
  end

endmodule
`default_nettype wire

[hw/rtl/noctce_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noctce_checker
// Port-level checks for the link load estimator.
// ----------------------------------------------------------------------------
module noctce_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [207:0] out_tdata,
  input wire logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while a message is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero fields");

  a_no_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[192] |-> out_tdata[207:128] == '0)
    else $error("bottleneck fields set without a loaded link");

endmodule

bind noc_traffic_contention_estimator noctce_checker u_noctce_checker (.*);
`default_nettype wire
